@@ rtl/plhm_pkg.sv @@
// Shared types and constants for the peak-hold level bar meter.
// No dependencies; imported by every module of the block.
`default_nettype none

package plhm_pkg;

   localparam int MID_BITS    = 10;
   localparam int LEN_BITS    = 8;
   localparam int THR_BITS    = 10;
   localparam int THR_WORD    = 40;
   localparam int BAR_BITS    = 8;
   localparam int PEAK_BITS   = 10;
   localparam int NUM_THR     = 8;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 40;

   localparam logic [MID_BITS-1:0]  MIDPOINT_RST = 10'd512;
   localparam logic [LEN_BITS-1:0]  FRAME_LEN_RST = 8'd30;
   // 15, 55, 100, 150 and 200, 255, 320, 400, first in the lowest bits
   localparam logic [THR_WORD-1:0]  THRESH_LOW_RST  = 40'd161166187535;
   localparam logic [THR_WORD-1:0]  THRESH_HIGH_RST = 40'd429832535240;

   localparam logic [PEAK_BITS-1:0] PEAK_MAX = 10'd1023;
   localparam logic [BAR_BITS-1:0]  BAR_FULL = 8'hFF;

   // pattern given when the level lies below threshold i
   localparam logic [BAR_BITS-1:0] BAR_LEVELS [NUM_THR] = '{
      8'h00, 8'h01, 8'h03, 8'h07, 8'h0F, 8'h1F, 8'h3F, 8'h7F
   };

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_MIDPOINT    = 2'd0,
      CSR_FRAME_LEN   = 2'd1,
      CSR_THRESH_LOW  = 2'd2,
      CSR_THRESH_HIGH = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [MID_BITS-1:0] midpoint;
      logic [LEN_BITS-1:0] frame_len;
      logic [THR_WORD-1:0] thresh_low;
      logic [THR_WORD-1:0] thresh_high;
   } cfg_type;

endpackage

`default_nettype wire

@@ rtl/plhm_csr.sv @@
// Configuration register file for the level meter.
// Depends on plhm_pkg; hands the register set to the core as cfg_type.
`default_nettype none

module plhm_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [plhm_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [plhm_pkg::CSR_DATA_BITS-1:0] csr_data,
   output      plhm_pkg::cfg_type                  cfg
);
   import plhm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_MIDPOINT:    cfg_in.midpoint    = csr_data[MID_BITS-1:0];
            CSR_FRAME_LEN:   cfg_in.frame_len   = csr_data[LEN_BITS-1:0];
            CSR_THRESH_LOW:  cfg_in.thresh_low  = csr_data[THR_WORD-1:0];
            CSR_THRESH_HIGH: cfg_in.thresh_high = csr_data[THR_WORD-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.midpoint    <= MIDPOINT_RST;
         cfg_ff.frame_len   <= FRAME_LEN_RST;
         cfg_ff.thresh_low  <= THRESH_LOW_RST;
         cfg_ff.thresh_high <= THRESH_HIGH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ rtl/plhm_core.sv @@
// Datapath of the level meter: input register, deviation and peak hold,
// frame counter, bar encoder and result register. Depends on plhm_pkg.
`default_nettype none

module plhm_core #(
   parameter int SAMPLE_BITS = 10
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire plhm_pkg::cfg_type              cfg,
   input  wire logic                           in_valid,
   output      logic                           in_ready,
   input  wire logic [SAMPLE_BITS-1:0]         in_sample,
   output      logic                           out_valid,
   input  wire logic                           out_ready,
   output      logic [plhm_pkg::BAR_BITS-1:0]  out_bar,
   output      logic [plhm_pkg::PEAK_BITS-1:0] out_peak
);
   import plhm_pkg::*;

   localparam int DEV_BITS = (SAMPLE_BITS > MID_BITS) ? SAMPLE_BITS : MID_BITS;

   logic                   smp_valid_ff, smp_valid_in;
   logic [SAMPLE_BITS-1:0] smp_ff;
   logic [DEV_BITS-1:0]    peak_ff, peak_in;
   logic [LEN_BITS-1:0]    count_ff, count_in;
   logic                   out_valid_ff, out_valid_in;
   logic [BAR_BITS-1:0]    bar_ff, bar_in;
   logic [PEAK_BITS-1:0]   opeak_ff, opeak_in;

   logic                   advance;
   logic [DEV_BITS-1:0]    raw_ext, mid_ext, dev, new_peak;
   logic [LEN_BITS-1:0]    next_count;
   logic                   frame_end;
   logic [2*THR_WORD-1:0]  thr_all;

   assign advance  = !out_valid_ff || out_ready;
   assign in_ready = !smp_valid_ff || advance;

   always_comb begin
      raw_ext    = DEV_BITS'(smp_ff);
      mid_ext    = DEV_BITS'(cfg.midpoint);
      dev        = (raw_ext > mid_ext) ? (raw_ext - mid_ext) : (mid_ext - raw_ext);
      new_peak   = (dev > peak_ff) ? dev : peak_ff;
      next_count = count_ff + LEN_BITS'(1);
      // a zero length acts as one; a count that wrapped also ends the frame
      frame_end  = (next_count >= cfg.frame_len) || (next_count == '0);
   end

   // first threshold that the peak lies below picks the pattern
   always_comb begin
      thr_all = {cfg.thresh_high, cfg.thresh_low};
      bar_in  = BAR_FULL;
      for (int i = NUM_THR - 1; i >= 0; i--) begin
         if (new_peak < DEV_BITS'(thr_all[i*THR_BITS +: THR_BITS])) begin
            bar_in = BAR_LEVELS[i];
         end
      end
      opeak_in = (new_peak > DEV_BITS'(PEAK_MAX)) ? PEAK_MAX : new_peak[PEAK_BITS-1:0];
   end

   always_comb begin
      smp_valid_in = smp_valid_ff;
      peak_in      = peak_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = smp_valid_ff && frame_end;
         if (smp_valid_ff) begin
            if (frame_end) begin
               peak_in  = '0;
               count_in = '0;
            end else begin
               peak_in  = new_peak;
               count_in = next_count;
            end
         end
      end
      if (in_ready) begin
         smp_valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         peak_ff      <= '0;
         count_ff     <= '0;
      end else begin
         smp_valid_ff <= smp_valid_in;
         out_valid_ff <= out_valid_in;
         peak_ff      <= peak_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         smp_ff <= in_sample;
      end
      if (advance && smp_valid_ff && frame_end) begin
         bar_ff   <= bar_in;
         opeak_ff <= opeak_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_bar   = bar_ff;
   assign out_peak  = opeak_ff;

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> in_ready)
      else $error("input blocked with empty result register");

   a_frame_clears: assert property (@(posedge clock) disable iff (reset)
      advance && smp_valid_ff && frame_end |=> peak_ff == '0 && count_ff == '0)
      else $error("peak or count not cleared after frame end");

   a_stall_holds_sample: assert property (@(posedge clock) disable iff (reset)
      smp_valid_ff && !advance |=> smp_valid_ff && $stable(smp_ff))
      else $error("held sample lost during output stall");

   a_bar_thermometer: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (bar_ff & (bar_ff + BAR_BITS'(1))) == '0)
      else $error("bar pattern is not a thermometer code");

endmodule

`default_nettype wire

@@ rtl/peak_hold_level_bar_meter.sv @@
// Top level of the peak-hold level bar meter.
// Depends on plhm_pkg, plhm_csr and plhm_core.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  req     | req_tvalid/tready, req_tdata     | in
//  rsp     | rsp_tvalid/tready, rsp_tdata     | out
//  csr     | csr_valid/ready, csr_index/data  | in
//
// One sample per cycle unless stalled; a sample enters the input register,
// then its frame result (if it ends a frame) enters the result register.
// Reset is synchronous: peak, count and both valid flags clear, registers
// return to their defaults. A stalled result stops the input register only
// once it is full; the stall reaches req_tready in the same cycle.
`default_nettype none

module peak_hold_level_bar_meter #(
   parameter int SAMPLE_BITS = 10
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   // [SAMPLE_BITS-1:0] sample, zero padding above
   input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]  req_tdata,
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [7:0] bar_pattern, [17:8] frame_peak, zero padding above
   output      logic [23:0]                        rsp_tdata,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [plhm_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [plhm_pkg::CSR_DATA_BITS-1:0] csr_data
);
   import plhm_pkg::*;

   cfg_type              cfg;
   logic [BAR_BITS-1:0]  bar;
   logic [PEAK_BITS-1:0] peak;

   plhm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   plhm_core #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_sample (req_tdata[SAMPLE_BITS-1:0]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_bar   (bar),
      .out_peak  (peak)
   );

   assign rsp_tdata = {6'd0, peak, bar};

endmodule

`default_nettype wire

@@ dv/peak_hold_level_bar_meter_tb.sv @@
// Self-checking testbench for peak_hold_level_bar_meter: random samples and
// register settings, with a built-in frame peak and bar predictor.
// Depends on plhm_pkg and the RTL of the block.
module peak_hold_level_bar_meter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import plhm_pkg::*;

   localparam int SAMPLE_BITS  = 10;
   localparam int REQ_W        = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
   localparam int DRAIN_CYCLES = 8;
   localparam int LIMIT_CYCLES = 200000;
   localparam int RAND_PHASES  = 12;
   localparam int PHASE_ITEMS  = 115;

   // one-sample frames that walk several bar levels of the default thresholds
   localparam int EDGE_COUNT = 11;
   localparam int EDGE_SAMPLES [EDGE_COUNT] = '{
      512, 498, 527, 457, 611, 362, 766, 257, 831, 912, 1023
   };
   localparam int SPREAD_STEPS [4] = '{20, 150, 450, 1023};

   typedef struct packed {
      logic [BAR_BITS-1:0]  bar;
      logic [PEAK_BITS-1:0] peak;
   } frame_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_W-1:0]         req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [23:0]              rsp_tdata;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   // predictor state, mirrors the block's registers
   cfg_type                  meter_cfg;
   int unsigned              held_peak;
   logic [LEN_BITS-1:0]      frame_count;

   logic [SAMPLE_BITS-1:0]   pending_samples[$];
   frame_result_type         frame_results_q[$];

   int unsigned tx_idle_pct = 0;
   int unsigned rx_idle_pct = 0;
   int unsigned samples_queued = 0;
   int unsigned samples_accepted = 0;
   int unsigned frames_checked = 0;
   int unsigned settings_used = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   peak_hold_level_bar_meter #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [BAR_BITS-1:0] bar_for_level(int unsigned level);
      logic [THR_BITS-1:0] thr;
      for (int i = 0; i < NUM_THR; i++) begin
         if (i < 4)
            thr = meter_cfg.thresh_low[(i % 4) * THR_BITS +: THR_BITS];
         else
            thr = meter_cfg.thresh_high[(i % 4) * THR_BITS +: THR_BITS];
         if (level < thr)
            return BAR_BITS'((1 << i) - 1);
      end
      return BAR_FULL;
   endfunction

   // deviation from midpoint, peak hold, frame count; pushes a result at frame end
   task automatic accumulate_sample(logic [SAMPLE_BITS-1:0] raw);
      int unsigned      s;
      int unsigned      m;
      int unsigned      dev;
      frame_result_type res;
      s = raw;
      m = meter_cfg.midpoint;
      dev = (s > m) ? s - m : m - s;
      if (dev > held_peak)
         held_peak = dev;
      frame_count = frame_count + 1'b1;
      if (frame_count >= meter_cfg.frame_len || frame_count == '0) begin
         res.bar  = bar_for_level(held_peak);
         res.peak = (held_peak > PEAK_MAX) ? PEAK_MAX : PEAK_BITS'(held_peak);
         frame_results_q.push_back(res);
         held_peak   = 0;
         frame_count = '0;
      end
   endtask

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h (result %0d)",
               what, got, want, frames_checked);
      error_count++;
   endtask

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MIDPOINT:    meter_cfg.midpoint    = value[MID_BITS-1:0];
         CSR_FRAME_LEN:   meter_cfg.frame_len   = value[LEN_BITS-1:0];
         CSR_THRESH_LOW:  meter_cfg.thresh_low  = value[THR_WORD-1:0];
         CSR_THRESH_HIGH: meter_cfg.thresh_high = value[THR_WORD-1:0];
         default: ;
      endcase
   endtask

   // all items taken and answered, then let items without a result clear the pipe
   task automatic settle();
      while (samples_accepted != samples_queued || frame_results_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic queue_sample(logic [SAMPLE_BITS-1:0] raw);
      pending_samples.push_back(raw);
      samples_queued++;
   endtask

   // sample driver and input-side predictor
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            accumulate_sample(req_tdata[SAMPLE_BITS-1:0]);
            samples_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_samples.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
               req_tdata  <= REQ_W'(pending_samples.pop_front());
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      frame_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (frame_results_q.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata, 0);
            end else begin
               want = frame_results_q.pop_front();
               if (rsp_tdata[7:0] !== want.bar)
                  report_mismatch("bar_pattern", rsp_tdata[7:0], want.bar);
               if (rsp_tdata[17:8] !== want.peak)
                  report_mismatch("frame_peak", rsp_tdata[17:8], want.peak);
            end
            frames_checked++;
         end
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("peak_hold_level_bar_meter test failed");
         $finish;
      end
   end

   initial begin
      logic [CSR_DATA_BITS-1:0] word;
      logic [2*THR_WORD-1:0]    thr_pack;
      int                       level;
      int                       spread;
      int                       val;
      int                       pick;

      meter_cfg.midpoint    = MIDPOINT_RST;
      meter_cfg.frame_len   = FRAME_LEN_RST;
      meter_cfg.thresh_low  = THRESH_LOW_RST;
      meter_cfg.thresh_high = THRESH_HIGH_RST;
      held_peak   = 0;
      frame_count = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      tx_idle_pct = 13;
      rx_idle_pct = 61;

      // one-sample frames against the default thresholds: several bar levels
      write_register(CSR_FRAME_LEN, 40'd1);
      settings_used++;
      for (int i = 0; i < EDGE_COUNT; i++)
         queue_sample(SAMPLE_BITS'(EDGE_SAMPLES[i]));
      settle();

      // midpoint at both ends: largest possible deviation
      write_register(CSR_MIDPOINT, 40'd0);
      queue_sample(SAMPLE_BITS'(SAMPLE_MAX));
      queue_sample('0);
      settle();
      write_register(CSR_MIDPOINT, 40'd1023);
      queue_sample('0);
      settle();

      // zero frame length acts as one
      write_register(CSR_FRAME_LEN, 40'd0);
      queue_sample(SAMPLE_BITS'(700));
      queue_sample(SAMPLE_BITS'(1000));
      settle();

      // frame length cut below the count already reached
      write_register(CSR_FRAME_LEN, 40'd200);
      repeat (6) queue_sample(SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)));
      settle();
      write_register(CSR_FRAME_LEN, 40'd2);
      queue_sample(SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)));
      settle();
      settings_used += 4;

      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         if (phase == 4) begin
            tx_idle_pct = 61;
            rx_idle_pct = 13;
         end else if (phase == 8) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end

         if (phase == 0 || $urandom_range(0, 9) < 7) begin
            pick = $urandom_range(0, 5);
            word = CSR_DATA_BITS'({$urandom(), $urandom()});
            if (pick == 0)      word[MID_BITS-1:0] = '0;
            else if (pick == 1) word[MID_BITS-1:0] = '1;
            else if (pick == 2) word[MID_BITS-1:0] = MIDPOINT_RST;
            if ($urandom_range(0, 1) == 0)
               word[CSR_DATA_BITS-1:MID_BITS] = '0;
            write_register(CSR_MIDPOINT, word);
         end

         if (phase == 0 || $urandom_range(0, 9) < 7) begin
            pick = $urandom_range(0, 9);
            word = CSR_DATA_BITS'({$urandom(), $urandom()});
            if (pick < 4)       word[LEN_BITS-1:0] = LEN_BITS'($urandom_range(1, 8));
            else if (pick < 6)  word[LEN_BITS-1:0] = LEN_BITS'($urandom_range(9, 40));
            else if (pick == 6) word[LEN_BITS-1:0] = '0;
            else if (pick == 7) word[LEN_BITS-1:0] = LEN_BITS'(1);
            else if (pick == 8) word[LEN_BITS-1:0] = '1;
            if ($urandom_range(0, 1) == 0)
               word[CSR_DATA_BITS-1:LEN_BITS] = '0;
            write_register(CSR_FRAME_LEN, word);
         end

         if (phase == 0 || $urandom_range(0, 9) < 7) begin
            case (phase % 4)
               0: begin
                  // ascending thresholds, the usual meter shape
                  level = 0;
                  for (int i = 0; i < NUM_THR; i++) begin
                     level += $urandom_range(0, 140);
                     if (level > 1023)
                        level = 1023;
                     thr_pack[i * THR_BITS +: THR_BITS] = THR_BITS'(level);
                  end
               end
               1: thr_pack = (2*THR_WORD)'({$urandom(), $urandom(), $urandom()});
               2: begin
                  thr_pack[THR_WORD-1:0] = $urandom_range(0, 1) ? '1 : '0;
                  thr_pack[2*THR_WORD-1:THR_WORD] = $urandom_range(0, 1) ? '1 : '0;
               end
               default: thr_pack = {THRESH_HIGH_RST, THRESH_LOW_RST};
            endcase
            write_register(CSR_THRESH_LOW, thr_pack[THR_WORD-1:0]);
            write_register(CSR_THRESH_HIGH, thr_pack[2*THR_WORD-1:THR_WORD]);
         end
         settings_used++;

         spread = 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 23 == 0)
               spread = SPREAD_STEPS[$urandom_range(0, 3)];
            if (spread >= 1023) begin
               val = $urandom_range(0, SAMPLE_MAX);
            end else begin
               val = int'($urandom_range(0, spread));
               val = $urandom_range(0, 1) ? int'(meter_cfg.midpoint) + val
                                          : int'(meter_cfg.midpoint) - val;
               if (val < 0)
                  val = 0;
               if (val > SAMPLE_MAX)
                  val = SAMPLE_MAX;
            end
            queue_sample(SAMPLE_BITS'(val));
         end
         settle();
      end

      $display("Ran %0d samples through %0d register settings; %0d frame results checked.",
               samples_accepted, settings_used, frames_checked);
      $display("Stall mixes: sender-heavy, receiver-heavy and none; %0d mismatches.",
               error_count);
      if (error_count == 0)
         $display("peak_hold_level_bar_meter test passed");
      else
         $display("peak_hold_level_bar_meter test failed");
      $finish;
   end

endmodule
